### rtl/rbpa_pkg.sv
// Shared constants and types for the region bump page allocator.
// No dependencies; every other file in this block but rbpa_ram imports this package.
package rbpa_pkg;

   localparam int MAX_REGIONS = 64;
   localparam int PAGE_BYTES  = 4096;

   localparam int FUNC_W   = 1;
   localparam int SLOT_W   = 6;
   localparam int COUNT_W  = 7;
   localparam int ADDR_W   = 52;
   localparam int LENGTH_W = 53;
   localparam int IDX_W    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

   // One region table entry as it sits in the RAM.
   typedef struct packed {
      logic                usable;
      logic [LENGTH_W-1:0] length;
      logic [ADDR_W-1:0]   base;
   } region_entry_type;

   localparam int ENTRY_W = $bits(region_entry_type);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 1'b0,
      FUNC_ALLOC = 1'b1
   } func_type;

   localparam logic [COUNT_W-1:0]  REGIONS_MAX_C = COUNT_W'(MAX_REGIONS);
   localparam logic [LENGTH_W:0]   PAGE_WIDE_C   = (LENGTH_W+1)'(PAGE_BYTES);
   localparam logic [LENGTH_W-1:0] PAGE_LEN_C    = LENGTH_W'(PAGE_BYTES);

endpackage

### rtl/rbpa_req_if.sv
// Request channel of the region bump page allocator: valid/ready plus payload.
// Depends on rbpa_pkg for the field widths.
interface rbpa_req_if
   import rbpa_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SLOT_W-1:0]   region_slot;
   logic [ADDR_W-1:0]   region_base;
   logic [LENGTH_W-1:0] region_length;
   logic                region_usable;

   modport source (
      output valid, func, region_slot, region_base, region_length, region_usable,
      input  ready
   );
   modport sink (
      input  valid, func, region_slot, region_base, region_length, region_usable,
      output ready
   );
endinterface

### rtl/rbpa_rsp_if.sv
// Response channel of the region bump page allocator: valid/ready plus payload.
// Depends on rbpa_pkg for the field widths.
interface rbpa_rsp_if
   import rbpa_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] page_address;
   logic              out_of_memory;

   modport source (
      output valid, page_address, out_of_memory,
      input  ready
   );
   modport sink (
      input  valid, page_address, out_of_memory,
      output ready
   );
endinterface

### rtl/rbpa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No package dependencies.
module rbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/region_bump_page_allocator.sv
// Region bump page allocator: a load request writes one region table entry and is
// answered from the response register. An allocation scans regions from the cursor,
// one RAM read each, until it grants a page or runs out and answers out of memory.
// One request is in flight at a time; a new one is taken as the response leaves.
// Synchronous active-high reset clears the cursor, offset, count and control;
// the region table holds no reset value and must be loaded before use.
module region_bump_page_allocator
   import rbpa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   rbpa_req_if.sink      req_chan,
   rbpa_rsp_if.source    rsp_chan,
   input  logic          csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  cursor_ff, cursor_in;
   logic [LENGTH_W-1:0] offset_ff, offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_page_ff, rsp_page_in;
   logic                rsp_oom_ff, rsp_oom_in;

   logic [COUNT_W-1:0]  limit;
   logic [COUNT_W-1:0]  cursor_next;
   logic                req_fire;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [COUNT_W-1:0]  ram_rd_idx;
   region_entry_type    wr_entry;
   region_entry_type    rd_entry;
   logic [ENTRY_W-1:0]  rd_raw;
   logic [LENGTH_W:0]   page_end;
   logic                fits;

   rbpa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_REGIONS)
   ) u_region_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_chan.region_slot[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_idx[IDX_W-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_entry = region_entry_type'(rd_raw);

   assign wr_entry.usable = req_chan.region_usable;
   assign wr_entry.length = req_chan.region_length;
   assign wr_entry.base   = req_chan.region_base;

   assign limit = (count_ff > REGIONS_MAX_C) ? REGIONS_MAX_C : count_ff;

   // A new request is taken only when the response register is free or
   // being emptied in this cycle.
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign ram_wr_en = req_fire && (req_chan.func == FUNC_LOAD)
                      && ({1'b0, req_chan.region_slot} < REGIONS_MAX_C);

   assign cursor_next = cursor_ff + COUNT_W'(1);
   assign page_end    = {1'b0, offset_ff} + PAGE_WIDE_C;
   assign fits        = rd_entry.usable && (page_end <= {1'b0, rd_entry.length});

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      cursor_in    = cursor_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_page_in  = rsp_page_ff;
      rsp_oom_in   = rsp_oom_ff;
      ram_rd_en    = 1'b0;
      ram_rd_idx   = cursor_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.func == FUNC_LOAD) begin
                  rsp_valid_in = 1'b1;
                  rsp_page_in  = '0;
                  rsp_oom_in   = 1'b0;
               end else if (cursor_ff >= limit) begin
                  rsp_valid_in = 1'b1;
                  rsp_page_in  = '0;
                  rsp_oom_in   = 1'b1;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (fits) begin
               rsp_valid_in = 1'b1;
               rsp_page_in  = rd_entry.base + offset_ff[ADDR_W-1:0];
               rsp_oom_in   = 1'b0;
               offset_in    = offset_ff + PAGE_LEN_C;
               state_in     = S_IDLE;
            end else begin
               // This region is used up or unusable: move on with a fresh offset.
               offset_in = '0;
               cursor_in = cursor_next;
               if (cursor_next >= limit) begin
                  rsp_valid_in = 1'b1;
                  rsp_page_in  = '0;
                  rsp_oom_in   = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  ram_rd_en  = 1'b1;
                  ram_rd_idx = cursor_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_page_ff <= rsp_page_in;
      rsp_oom_ff  <= rsp_oom_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.page_address  = rsp_page_ff;
   assign rsp_chan.out_of_memory = rsp_oom_ff;

endmodule

### sim/region_bump_page_allocator_test.sv
// Self-checking testbench for region_bump_page_allocator: region loads and page
// allocations are checked against an in-bench prediction of the region cursor.
// Depends on rbpa_pkg, rbpa_req_if, rbpa_rsp_if and the allocator RTL.
module region_bump_page_allocator_test;
   import rbpa_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASE_ITEMS  = 140;
   localparam int PHASE_REGION_COUNT [6] = '{16, 28, 40, 52, 64, 127};

   typedef struct {
      func_type            func;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   base;
      logic [LENGTH_W-1:0] length;
      logic                usable;
   } page_req_t;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic              oom;
   } page_grant_t;

   typedef struct {
      page_req_t   req;
      page_grant_t grant;
      bit          wait_drain;
   } queued_req_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   rbpa_req_if req_chan ();
   rbpa_rsp_if rsp_chan ();

   region_bump_page_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted allocator state, advanced as requests are queued.
   logic [ADDR_W-1:0]   region_base_tbl   [MAX_REGIONS];
   logic [LENGTH_W-1:0] region_len_tbl    [MAX_REGIONS];
   logic                region_usable_tbl [MAX_REGIONS];
   bit                  slot_loaded       [MAX_REGIONS];
   logic [COUNT_W-1:0]  region_count_cfg = '0;
   logic [COUNT_W-1:0]  scan_cursor      = '0;
   logic [LENGTH_W-1:0] page_offset      = '0;

   queued_req_t queued_requests [$];
   page_grant_t awaited_grants  [$];
   queued_req_t head_req;
   page_grant_t in_flight_grant;
   page_grant_t seen_grant;
   page_grant_t due_grant;

   int send_idle_pct  = 29;
   int recv_idle_pct  = 88;
   int mismatch_count = 0;
   int load_count     = 0;
   int alloc_count    = 0;
   int oom_count      = 0;
   int cycle_count    = 0;

   always #5 clock = ~clock;

   function automatic page_grant_t compute_grant(input page_req_t r);
      page_grant_t       g;
      int                lim;
      logic [LENGTH_W:0] reach;
      g.addr = '0;
      g.oom  = 1'b0;
      if (r.func == FUNC_LOAD) begin
         region_base_tbl[r.slot]   = r.base;
         region_len_tbl[r.slot]    = r.length;
         region_usable_tbl[r.slot] = r.usable;
         return g;
      end
      lim = (region_count_cfg > MAX_REGIONS) ? MAX_REGIONS : int'(region_count_cfg);
      while (int'(scan_cursor) < lim) begin
         reach = {1'b0, page_offset} + (LENGTH_W+1)'(PAGE_BYTES);
         if (region_usable_tbl[scan_cursor] &&
             reach <= {1'b0, region_len_tbl[scan_cursor]}) begin
            // The sum is cut to the address width, so bases near the top wrap.
            g.addr      = region_base_tbl[scan_cursor] + page_offset[ADDR_W-1:0];
            page_offset = reach[LENGTH_W-1:0];
            return g;
         end
         page_offset = '0;
         scan_cursor = scan_cursor + 1'b1;
      end
      g.oom = 1'b1;
      return g;
   endfunction

   task automatic queue_request(input func_type f, input int slot,
                                input logic [ADDR_W-1:0] base,
                                input logic [LENGTH_W-1:0] length,
                                input logic usable, input bit hold);
      queued_req_t q;
      q.req.func   = f;
      q.req.slot   = SLOT_W'(slot);
      q.req.base   = base;
      q.req.length = length;
      q.req.usable = usable;
      q.grant      = compute_grant(q.req);
      q.wait_drain = hold;
      if (f == FUNC_LOAD) begin
         slot_loaded[slot] = 1'b1;
      end
      queued_requests.push_back(q);
   endtask

   task automatic make_region(output logic [ADDR_W-1:0] base,
                              output logic [LENGTH_W-1:0] length,
                              output logic usable);
      int kind;
      kind   = $urandom_range(0, 99);
      base   = ADDR_W'({$urandom(), $urandom()});
      usable = ($urandom_range(0, 9) != 0);
      if (kind < 10) begin
         length = LENGTH_W'($urandom_range(0, PAGE_BYTES - 1));
      end else if (kind < 14) begin
         length = LENGTH_W'(1) << ADDR_W;
      end else if (kind < 18) begin
         length = {1'b0, ADDR_W'({$urandom(), $urandom()})};
      end else begin
         length = LENGTH_W'($urandom_range(1, 12)) * LENGTH_W'(PAGE_BYTES);
         if ($urandom_range(0, 3) == 0) begin
            length = length + LENGTH_W'($urandom_range(1, PAGE_BYTES - 1));
         end
      end
   endtask

   // Allocations only go out once every slot the scan could read has been loaded.
   task automatic queue_random_request(input bit hold);
      int                  lim;
      int                  gap;
      int                  pick;
      logic [ADDR_W-1:0]   base;
      logic [LENGTH_W-1:0] length;
      logic                usable;
      lim = (region_count_cfg > MAX_REGIONS) ? MAX_REGIONS : int'(region_count_cfg);
      gap = -1;
      for (int i = int'(scan_cursor); i < lim; i++) begin
         if (!slot_loaded[i] && gap < 0) begin
            gap = i;
         end
      end
      make_region(base, length, usable);
      pick = $urandom_range(0, 99);
      if (gap >= 0) begin
         queue_request(FUNC_LOAD, gap, base, length, usable, hold);
      end else if (pick < 55) begin
         queue_request(FUNC_ALLOC, $urandom_range(0, MAX_REGIONS - 1), base, length,
                       usable, hold);
      end else if (pick < 70 && int'(scan_cursor) < lim) begin
         queue_request(FUNC_LOAD, int'(scan_cursor), base, length, usable, hold);
      end else if (pick < 85 && int'(scan_cursor) < lim) begin
         queue_request(FUNC_LOAD, $urandom_range(lim - 1, int'(scan_cursor)), base,
                       length, usable, hold);
      end else begin
         queue_request(FUNC_LOAD, $urandom_range(0, MAX_REGIONS - 1), base, length,
                       usable, hold);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (queued_requests.size() > 0 || awaited_grants.size() > 0 || req_chan.valid) begin
         @(negedge clock);
      end
   endtask

   task automatic set_region_count(input int count);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(count);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      region_count_cfg = COUNT_W'(count);
   endtask

   // Request driver: while the channel is free, a new request may go out.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            awaited_grants.push_back(in_flight_grant);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (queued_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
                !(queued_requests[0].wait_drain && awaited_grants.size() > 0)) begin
               head_req = queued_requests.pop_front();
               in_flight_grant = head_req.grant;
               req_chan.valid         <= 1'b1;
               req_chan.func          <= head_req.req.func;
               req_chan.region_slot   <= head_req.req.slot;
               req_chan.region_base   <= head_req.req.base;
               req_chan.region_length <= head_req.req.length;
               req_chan.region_usable <= head_req.req.usable;
               if (head_req.req.func == FUNC_LOAD) begin
                  load_count++;
               end else begin
                  alloc_count++;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: each grant is checked against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_grant.addr = rsp_chan.page_address;
            seen_grant.oom  = rsp_chan.out_of_memory;
            if (awaited_grants.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual addr %h oom %b",
                        $time, seen_grant.addr, seen_grant.oom);
               mismatch_count++;
            end else begin
               due_grant = awaited_grants.pop_front();
               if (seen_grant.addr !== due_grant.addr) begin
                  $display("%0t: page_address mismatch: expected %h, actual %h",
                           $time, due_grant.addr, seen_grant.addr);
                  mismatch_count++;
               end
               if (seen_grant.oom !== due_grant.oom) begin
                  $display("%0t: out_of_memory mismatch: expected %b, actual %b",
                           $time, due_grant.oom, seen_grant.oom);
                  mismatch_count++;
               end
               if (due_grant.oom) begin
                  oom_count++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("region_bump_page_allocator regression: fail");
         $finish;
      end
   end

   initial begin
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_chan.valid         = 1'b0;
      req_chan.func          = FUNC_LOAD;
      req_chan.region_slot   = '0;
      req_chan.region_base   = '0;
      req_chan.region_length = '0;
      req_chan.region_usable = 1'b0;
      rsp_chan.ready         = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty table: the very first allocation is already out of memory.
      set_region_count(0);
      queue_request(FUNC_ALLOC, 0, '0, '0, 1'b0, 1'b0);
      // Slot 0 sits just below the top of the address space so its pages wrap.
      queue_request(FUNC_LOAD, 0, ADDR_W'(0) - ADDR_W'(PAGE_BYTES),
                    LENGTH_W'(3 * PAGE_BYTES), 1'b1, 1'b0);
      queue_request(FUNC_LOAD, 1, ADDR_W'('h1234_5678_9000), LENGTH_W'(1) << ADDR_W,
                    1'b0, 1'b0);
      queue_request(FUNC_LOAD, 2, ADDR_W'(PAGE_BYTES), LENGTH_W'(PAGE_BYTES - 1),
                    1'b1, 1'b0);
      queue_request(FUNC_LOAD, 3, ADDR_W'('hA_BCDE_F012_3000), LENGTH_W'(PAGE_BYTES),
                    1'b1, 1'b0);
      queue_request(FUNC_LOAD, 4, '1, '0, 1'b1, 1'b0);
      queue_request(FUNC_LOAD, MAX_REGIONS - 1, '1, {1'b0, {ADDR_W{1'b1}}}, 1'b1, 1'b0);

      // Three wrapped pages from slot 0, then a skip over unusable and short
      // regions to slot 3, then exhaustion that persists.
      set_region_count(5);
      repeat (6) queue_request(FUNC_ALLOC, MAX_REGIONS - 1, '1, '1, 1'b1, 1'b0);
      queue_request(FUNC_LOAD, 5, '1, LENGTH_W'(2 * PAGE_BYTES + 5), 1'b1, 1'b0);
      queue_request(FUNC_LOAD, 6, '0, LENGTH_W'(2 * PAGE_BYTES), 1'b1, 1'b0);

      // Raising the count resumes the scan from the stalled cursor.
      set_region_count(7);
      repeat (5) queue_request(FUNC_ALLOC, 0, '0, '0, 1'b0, 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         set_region_count(PHASE_REGION_COUNT[ph]);
         send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 88 : 0;
         recv_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 29 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_random_request(n == PHASE_ITEMS / 2);
         end
      end

      wait_idle();
      repeat (2 * MAX_REGIONS + 8) @(posedge clock);
      $display("Covered %0d region loads and %0d allocations over region counts 0 to 127.",
               load_count, alloc_count);
      $display("%0d pages granted, %0d out-of-memory responses, region cursor ended at %0d.",
               alloc_count - oom_count, oom_count, scan_cursor);
      if (mismatch_count == 0 && awaited_grants.size() == 0) begin
         $display("region_bump_page_allocator regression: pass");
      end else begin
         $display("region_bump_page_allocator regression: fail");
      end
      $finish;
   end

endmodule

### files.f
rtl/rbpa_pkg.sv
rtl/rbpa_req_if.sv
rtl/rbpa_rsp_if.sv
rtl/rbpa_ram.sv
rtl/region_bump_page_allocator.sv
sim/region_bump_page_allocator_test.sv
